// ===== design/kbkt_pkg.sv =====
// ----------------------------------------------------------------------------
// K-bucket table package
// Shared widths, operation and status codes, and the controller state type.
// ----------------------------------------------------------------------------
package kbkt_pkg;

    localparam int KEY_W    = 64;
    localparam int CNT_W    = 6;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 3;
    localparam int S_DATA_W = 2 * KEY_W;
    localparam int M_DATA_W = 72;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 6'd20;

    localparam logic [ACT_W-1:0] ACT_TOUCH   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REPLACE = 2'd2;

    localparam logic [STAT_W-1:0] ST_MOVED    = 3'd0;
    localparam logic [STAT_W-1:0] ST_ADDED    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_REPLACED = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_WRITE,
        S_DONE
    } kbkt_state_t;

endpackage

// ===== design/kbkt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kbkt_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/kademlia_kbucket_lru_table.sv =====
// ----------------------------------------------------------------------------
// Kademlia k-bucket LRU peer table
// Keeps peer keys from least to most recently seen in one RAM and performs
// touch, remove and replace operations by search, shift and write-back.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         tuser: action; tdata: node_key, new_key
// m_axis    out        tuser: status; tdata: entry_count, is_full, oldest_key
// cfg       in         bucket_limit write
//
// For a table of N entries, the search reads one entry per cycle up to the
// match, and a remove or move-to-back then shifts the later entries down one per
// cycle through the single RAM read port, so each entry is visited once. The
// next input transfer is taken only once the table is back in idle.
// A result that still waits on m_axis holds the table in its last step.
// Reset empties the table at once.
// ----------------------------------------------------------------------------
module kademlia_kbucket_lru_table #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // node_key [63:0], new_key [127:64]
    input  logic [kbkt_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // action [1:0]
    input  logic [kbkt_pkg::ACT_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // entry_count [5:0], is_full [6], oldest_key [70:7], zero [71]
    output logic [kbkt_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // status [2:0]
    output logic [kbkt_pkg::STAT_W-1:0]     m_axis_tuser,
    input  logic                            cfg_we,
    input  logic [kbkt_pkg::CNT_W-1:0]      cfg_wdata
);

    import kbkt_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);

    kbkt_state_t         state_reg, state_next;

    logic [CNT_W-1:0]    limit_reg;
    logic [CNT_W-1:0]    total_reg;
    logic [CNT_W-1:0]    ptr_reg;
    logic [CNT_W-1:0]    pend_idx_reg;
    logic                pend_reg;
    logic [CNT_W-1:0]    wr_idx_reg;
    logic [KEY_W-1:0]    wr_key_reg;
    logic [ACT_W-1:0]    act_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [KEY_W-1:0]    nkey_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [KEY_W-1:0]    oldest_reg;

    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [STAT_W-1:0]   out_user_reg;

    logic [CNT_W-1:0]    eff_lim;
    logic                hit;
    logic                more;
    logic                miss;
    logic                at_limit;
    logic                out_load;
    logic                in_xfer;

    logic                ram_wr_en;
    logic [IW-1:0]       ram_wr_addr;
    logic [KEY_W-1:0]    ram_wr_data;
    logic [IW-1:0]       ram_rd_addr;
    logic [KEY_W-1:0]    ram_rd_data;

    kbkt_ram #(
        .DATA_W (KEY_W),
        .DEPTH  (MAX_ENTRIES)
    ) u_keys (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign eff_lim  = (32'(limit_reg) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : limit_reg;
    assign hit      = pend_reg && (ram_rd_data == key_reg);
    assign more     = ptr_reg < total_reg;
    assign miss     = !pend_reg && !more;
    assign at_limit = total_reg >= eff_lim;
    assign out_load = !out_valid_reg || m_axis_tready;
    assign in_xfer  = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    case (act_reg)
                        ACT_TOUCH, ACT_REMOVE: state_next = S_SHIFT;
                        ACT_REPLACE:           state_next = S_WRITE;
                        default:               state_next = S_DONE;
                    endcase
                end
                else if (miss)
                begin
                    if (act_reg == ACT_TOUCH && !at_limit)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SHIFT:
            begin
                if (miss)
                begin
                    state_next = (act_reg == ACT_REMOVE) ? S_DONE : S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_rd_addr   = IW'(ptr_reg);
        ram_wr_en     = 1'b0;
        ram_wr_addr   = IW'(wr_idx_reg);
        ram_wr_data   = wr_key_reg;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            S_SHIFT:
            begin
                ram_wr_en   = pend_reg;
                ram_wr_addr = IW'(pend_idx_reg - 1'b1);
                ram_wr_data = ram_rd_data;
            end
            S_WRITE:
            begin
                ram_wr_en = 1'b1;
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_RESET;
            total_reg     <= '0;
            ptr_reg       <= '0;
            pend_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            wr_idx_reg    <= '0;
            wr_key_reg    <= '0;
            status_reg    <= ST_NOTFOUND;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (state_reg == S_DONE && out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        ptr_reg  <= '0;
                        pend_reg <= 1'b0;
                        if (total_reg > eff_lim)
                        begin
                            total_reg <= eff_lim;
                        end
                    end
                end
                S_SEARCH:
                begin
                    if (hit)
                    begin
                        pend_reg <= 1'b0;
                        ptr_reg  <= pend_idx_reg + 1'b1;
                        case (act_reg)
                            ACT_TOUCH:
                            begin
                                status_reg <= ST_MOVED;
                                wr_idx_reg <= total_reg - 1'b1;
                                wr_key_reg <= key_reg;
                            end
                            ACT_REMOVE:
                            begin
                                status_reg <= ST_REMOVED;
                            end
                            ACT_REPLACE:
                            begin
                                status_reg <= ST_REPLACED;
                                wr_idx_reg <= pend_idx_reg;
                                wr_key_reg <= nkey_reg;
                            end
                            default:
                            begin
                                status_reg <= ST_NOTFOUND;
                            end
                        endcase
                    end
                    else if (miss)
                    begin
                        if (act_reg == ACT_TOUCH)
                        begin
                            if (at_limit)
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                status_reg <= ST_ADDED;
                                wr_idx_reg <= total_reg;
                                wr_key_reg <= key_reg;
                                total_reg  <= total_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            status_reg <= ST_NOTFOUND;
                        end
                    end
                    else if (more)
                    begin
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= ptr_reg;
                        ptr_reg      <= ptr_reg + 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                end
                S_SHIFT:
                begin
                    if (more)
                    begin
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= ptr_reg;
                        ptr_reg      <= ptr_reg + 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg && act_reg == ACT_REMOVE)
                        begin
                            total_reg <= total_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    pend_reg <= pend_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            act_reg  <= s_axis_tuser;
            key_reg  <= s_axis_tdata[KEY_W-1:0];
            nkey_reg <= s_axis_tdata[S_DATA_W-1:KEY_W];
        end
        if (ram_wr_en && ram_wr_addr == '0)
        begin
            oldest_reg <= ram_wr_data;
        end
        if (state_reg == S_DONE && out_load)
        begin
            out_user_reg <= status_reg;
            out_data_reg <= {1'b0,
                             (total_reg != '0) ? oldest_reg : {KEY_W{1'b0}},
                             at_limit,
                             total_reg};
        end
    end

endmodule
